>>> hw/rtl/swsr_pkg.sv
// Shared types, register codes and helper functions for the single-wire sensor reader.
`timescale 1ns / 1ps
`default_nettype none

package swsr_pkg;

   // Tick counter width; the counter saturates at its maximum.
   localparam int TIMER_BITS = 16;
   localparam int CFG_W      = 16;
   localparam int DLY_W      = 10;
   localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

   typedef logic [TIMER_BITS-1:0] timer_type;

   localparam timer_type TIMER_MAX = {TIMER_BITS{1'b1}};

   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_LOW      = 3'd0,
      CSR_RELEASE        = 3'd1,
      CSR_RESP_LOW_DLY   = 3'd2,
      CSR_RESP_HIGH_DLY  = 3'd3,
      CSR_PRE_DATA_DLY   = 3'd4,
      CSR_BIT_SAMPLE_DLY = 3'd5,
      CSR_WAIT_TIMEOUT   = 3'd6
   } csr_index_type;

   localparam logic [CFG_W-1:0] START_LOW_RST      = 16'd18000;
   localparam logic [DLY_W-1:0] RELEASE_RST        = 10'd30;
   localparam logic [DLY_W-1:0] RESP_LOW_DLY_RST   = 10'd40;
   localparam logic [DLY_W-1:0] RESP_HIGH_DLY_RST  = 10'd80;
   localparam logic [DLY_W-1:0] PRE_DATA_DLY_RST   = 10'd40;
   localparam logic [DLY_W-1:0] BIT_SAMPLE_DLY_RST = 10'd40;
   localparam logic [CFG_W-1:0] WAIT_TIMEOUT_RST   = 16'd100;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_NO_RESPONSE  = 2'd1,
      STATUS_BAD_CHECKSUM = 2'd2
   } status_type;

   localparam int BYTE_CHECKSUM = 4;
   localparam int BYTE_TEMP     = 2;
   localparam int BYTE_HUMIDITY = 0;

   localparam logic [7:0] TIMEOUT_BYTE = 8'hFF;

   // 9/5 is taken as 471861 / 2^18, exact for every byte value.
   localparam logic [27:0] F_SCALE = 28'd471861;
   localparam int          F_SHIFT = 18;
   localparam logic [8:0]  F_OFFSET = 9'd32;

   localparam int REQ_W = 8;
   localparam int RSP_W = 32;

   // True once the advanced count has reached the limit (limit clamps to counter max).
   function automatic logic limit_hit(timer_type cnt, logic [CFG_W-1:0] lim);
      logic [CMP_W-1:0] c;
      logic [CMP_W-1:0] l;
      c = CMP_W'(cnt);
      l = CMP_W'(lim);
      return (c >= l) || (cnt == TIMER_MAX);
   endfunction

   function automatic logic [8:0] to_fahrenheit(logic [7:0] celsius);
      logic [27:0] prod;
      prod = 28'(celsius) * F_SCALE;
      return 9'(prod >> F_SHIFT) + F_OFFSET;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/single_wire_sensor_reader.sv
// Single-wire sensor reader: start pulse, response check, 40-bit read, checksum.
// A tick word's result is registered, presented in the cycle after its acceptance.
// Throughput: one tick word per cycle unless stalled; the state update and result
//   are one registered pass, and the output register refills as its word is taken.
// Reset: synchronous, active high; idle phase, stores cleared, config at defaults.
`timescale 1ns / 1ps
`default_nettype none

module single_wire_sensor_reader (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // req_tdata: [0] start_req, [1] line_in, [7:2] zero
   input  wire logic [swsr_pkg::REQ_W-1:0]         req_tdata,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // rsp_tdata: [0] drive_enable, [1] drive_level, [2] busy_res, [3] done_res,
   //   [5:4] status, [13:6] humidity, [21:14] temperature_c,
   //   [30:22] temperature_f, [31] zero
   output logic [swsr_pkg::RSP_W-1:0]              rsp_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [swsr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [swsr_pkg::CFG_W-1:0]         csr_wdata
);
   import swsr_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE       = 4'd0,
      PH_START_LOW  = 4'd1,
      PH_START_HIGH = 4'd2,
      PH_RESP_LOW   = 4'd3,
      PH_RESP_HIGH  = 4'd4,
      PH_PRE_DATA   = 4'd5,
      PH_WAIT_HIGH  = 4'd6,
      PH_SAMPLE     = 4'd7,
      PH_WAIT_LOW   = 4'd8
   } phase_type;

   // configuration
   logic [CFG_W-1:0] start_low_ff;
   logic [DLY_W-1:0] release_ff;
   logic [DLY_W-1:0] resp_low_dly_ff;
   logic [DLY_W-1:0] resp_high_dly_ff;
   logic [DLY_W-1:0] pre_data_dly_ff;
   logic [DLY_W-1:0] bit_sample_dly_ff;
   logic [CFG_W-1:0] wait_timeout_ff;

   // reading state
   phase_type  phase_ff,     phase_in;
   timer_type  count_ff,     count_in;
   logic [2:0] bit_idx_ff,   bit_idx_in;
   logic [2:0] byte_idx_ff,  byte_idx_in;
   logic [7:0] shift_ff,     shift_in;
   logic       responded_ff, responded_in;
   logic [7:0] humidity_ff,  humidity_in;
   logic [7:0] temp_ff,      temp_in;
   logic [7:0] checksum_ff,  checksum_in;
   status_type status_ff,    status_in;

   // output register
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic             rsp_valid_ff;

   logic       accept;
   logic       start_req;
   logic       line_in;
   timer_type  count_inc;
   logic       done;
   logic       byte_done;
   logic [7:0] byte_val;
   logic       drive_en;
   logic       drive_lvl;
   logic [8:0] temp_f;

   assign start_req  = req_tdata[0];
   assign line_in    = req_tdata[1];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tvalid = rsp_valid_ff;

   assign count_inc = (count_ff == TIMER_MAX) ? count_ff : count_ff + timer_type'(1);

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      bit_idx_in   = bit_idx_ff;
      byte_idx_in  = byte_idx_ff;
      shift_in     = shift_ff;
      responded_in = responded_ff;
      humidity_in  = humidity_ff;
      temp_in      = temp_ff;
      checksum_in  = checksum_ff;
      status_in    = status_ff;
      done         = 1'b0;
      byte_done    = 1'b0;
      byte_val     = TIMEOUT_BYTE;

      case (phase_ff)
         PH_IDLE: begin
            if (start_req) begin
               responded_in = 1'b0;
               phase_in     = PH_START_LOW;
               count_in     = '0;
            end
         end
         PH_START_LOW: begin
            count_in = count_inc;
            if (limit_hit(count_inc, start_low_ff)) begin
               phase_in = PH_START_HIGH;
               count_in = '0;
            end
         end
         PH_START_HIGH: begin
            count_in = count_inc;
            if (limit_hit(count_inc, CFG_W'(release_ff))) begin
               phase_in = PH_RESP_LOW;
               count_in = '0;
            end
         end
         PH_RESP_LOW: begin
            count_in = count_inc;
            if (limit_hit(count_inc, CFG_W'(resp_low_dly_ff))) begin
               count_in = '0;
               if (!line_in) begin
                  phase_in = PH_RESP_HIGH;
               end else begin
                  status_in = STATUS_NO_RESPONSE;
                  phase_in  = PH_IDLE;
                  done      = 1'b1;
               end
            end
         end
         PH_RESP_HIGH: begin
            count_in = count_inc;
            if (limit_hit(count_inc, CFG_W'(resp_high_dly_ff))) begin
               responded_in = line_in;
               phase_in     = PH_PRE_DATA;
               count_in     = '0;
            end
         end
         PH_PRE_DATA: begin
            count_in = count_inc;
            if (limit_hit(count_inc, CFG_W'(pre_data_dly_ff))) begin
               count_in = '0;
               if (responded_ff) begin
                  byte_idx_in = '0;
                  bit_idx_in  = '0;
                  shift_in    = '0;
                  phase_in    = PH_WAIT_HIGH;
               end else begin
                  status_in = STATUS_NO_RESPONSE;
                  phase_in  = PH_IDLE;
                  done      = 1'b1;
               end
            end
         end
         PH_WAIT_HIGH: begin
            if (line_in) begin
               phase_in = PH_SAMPLE;
               count_in = '0;
            end else begin
               count_in = count_inc;
               if (limit_hit(count_inc, wait_timeout_ff)) begin
                  byte_done = 1'b1;
               end
            end
         end
         PH_SAMPLE: begin
            count_in = count_inc;
            if (limit_hit(count_inc, CFG_W'(bit_sample_dly_ff))) begin
               // bits arrive MSB first
               shift_in[~bit_idx_ff] = line_in;
               count_in = '0;
               if (line_in) begin
                  phase_in = PH_WAIT_LOW;
               end else if (bit_idx_ff == 3'd7) begin
                  byte_done = 1'b1;
                  byte_val  = shift_in;
               end else begin
                  bit_idx_in = bit_idx_ff + 3'd1;
                  phase_in   = PH_WAIT_HIGH;
               end
            end
         end
         PH_WAIT_LOW: begin
            if (!line_in) begin
               count_in = '0;
               if (bit_idx_ff == 3'd7) begin
                  byte_done = 1'b1;
                  byte_val  = shift_ff;
               end else begin
                  bit_idx_in = bit_idx_ff + 3'd1;
                  phase_in   = PH_WAIT_HIGH;
               end
            end else begin
               count_in = count_inc;
               if (limit_hit(count_inc, wait_timeout_ff)) begin
                  byte_done = 1'b1;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
            count_in = '0;
         end
      endcase

      // Store the finished byte; the checksum byte ends the reading.
      if (byte_done) begin
         count_in = '0;
         case (byte_idx_ff)
            3'(BYTE_HUMIDITY): humidity_in = byte_val;
            3'(BYTE_TEMP):     temp_in     = byte_val;
            3'(BYTE_CHECKSUM): checksum_in = byte_val;
            default: ;
         endcase
         if (byte_idx_ff >= 3'(BYTE_CHECKSUM)) begin
            status_in = ({1'b0, checksum_in} == ({1'b0, humidity_in} + {1'b0, temp_in}))
                        ? STATUS_OK : STATUS_BAD_CHECKSUM;
            phase_in  = PH_IDLE;
            done      = 1'b1;
         end else begin
            byte_idx_in = byte_idx_ff + 3'd1;
            bit_idx_in  = '0;
            shift_in    = '0;
            phase_in    = PH_WAIT_HIGH;
         end
      end
   end

   always_comb begin
      drive_en    = (phase_in == PH_START_LOW) || (phase_in == PH_START_HIGH);
      drive_lvl   = (phase_in == PH_START_HIGH);
      temp_f      = to_fahrenheit(temp_in);
      rsp_data_in = {1'b0, temp_f, temp_in, humidity_in, status_in, done,
                     (phase_in != PH_IDLE), drive_lvl, drive_en};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_low_ff      <= START_LOW_RST;
         release_ff        <= RELEASE_RST;
         resp_low_dly_ff   <= RESP_LOW_DLY_RST;
         resp_high_dly_ff  <= RESP_HIGH_DLY_RST;
         pre_data_dly_ff   <= PRE_DATA_DLY_RST;
         bit_sample_dly_ff <= BIT_SAMPLE_DLY_RST;
         wait_timeout_ff   <= WAIT_TIMEOUT_RST;
         phase_ff          <= PH_IDLE;
         count_ff          <= '0;
         bit_idx_ff        <= '0;
         byte_idx_ff       <= '0;
         shift_ff          <= '0;
         responded_ff      <= 1'b0;
         humidity_ff       <= '0;
         temp_ff           <= '0;
         checksum_ff       <= '0;
         status_ff         <= STATUS_OK;
         rsp_valid_ff      <= 1'b0;
         rsp_data_ff       <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_START_LOW:      start_low_ff      <= csr_wdata;
               CSR_RELEASE:        release_ff        <= csr_wdata[DLY_W-1:0];
               CSR_RESP_LOW_DLY:   resp_low_dly_ff   <= csr_wdata[DLY_W-1:0];
               CSR_RESP_HIGH_DLY:  resp_high_dly_ff  <= csr_wdata[DLY_W-1:0];
               CSR_PRE_DATA_DLY:   pre_data_dly_ff   <= csr_wdata[DLY_W-1:0];
               CSR_BIT_SAMPLE_DLY: bit_sample_dly_ff <= csr_wdata[DLY_W-1:0];
               CSR_WAIT_TIMEOUT:   wait_timeout_ff   <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            phase_ff     <= phase_in;
            count_ff     <= count_in;
            bit_idx_ff   <= bit_idx_in;
            byte_idx_ff  <= byte_idx_in;
            shift_ff     <= shift_in;
            responded_ff <= responded_in;
            humidity_ff  <= humidity_in;
            temp_ff      <= temp_in;
            checksum_ff  <= checksum_in;
            status_ff    <= status_in;
            rsp_data_ff  <= rsp_data_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            // word taken, nothing new to hold
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

>>> tb/tb_single_wire_sensor_reader.sv
// Testbench for the single-wire sensor reader: emulated sensor, tick predictor and result checker.
`timescale 1ns / 1ps

module tb_single_wire_sensor_reader;
   import swsr_pkg::*;

   typedef enum int {
      ST_IDLE, ST_START_LOW, ST_START_HIGH, ST_RESP_LOW, ST_RESP_HIGH,
      ST_PRE_DATA, ST_WAIT_HIGH, ST_SAMPLE, ST_WAIT_LOW
   } wire_phase_type;

   typedef enum int {
      RD_OK, RD_BAD_SUM, RD_SUM_OVERFLOW, RD_NO_LOW, RD_NO_HIGH, RD_TIMEOUTS
   } reading_kind_type;

   // Lowest bit last, so the struct lines up with rsp_tdata[30:0].
   typedef struct packed {
      logic [8:0] temp_f;
      logic [7:0] temp_c;
      logic [7:0] hum;
      logic [1:0] status;
      logic       done;
      logic       busy;
      logic       drv_lvl;
      logic       drv_en;
   } tick_result_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int unsigned DLY_MASK = (1 << DLY_W) - 1;

   class reading_scoreboard;
      int unsigned     low_ticks, high_ticks, ans_low_dly, ans_high_dly;
      int unsigned     pre_dly, sample_dly, edge_timeout;
      wire_phase_type  phase;
      int unsigned     tick_cnt, bit_idx, byte_idx;
      logic [7:0]      shift_val, hum, temp, csum;
      logic [1:0]      stat;
      bit              answered;
      tick_result_type expected_q[$];
      int              errors;

      function new();
         low_ticks    = START_LOW_RST;
         high_ticks   = RELEASE_RST;
         ans_low_dly  = RESP_LOW_DLY_RST;
         ans_high_dly = RESP_HIGH_DLY_RST;
         pre_dly      = PRE_DATA_DLY_RST;
         sample_dly   = BIT_SAMPLE_DLY_RST;
         edge_timeout = WAIT_TIMEOUT_RST;
         phase        = ST_IDLE;
         tick_cnt     = 0;
         bit_idx      = 0;
         byte_idx     = 0;
         shift_val    = '0;
         hum          = '0;
         temp         = '0;
         csum         = '0;
         stat         = STATUS_OK;
         answered     = 0;
         errors       = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [15:0] v);
         case (idx)
            CSR_START_LOW:      low_ticks    = v;
            CSR_RELEASE:        high_ticks   = v & DLY_MASK;
            CSR_RESP_LOW_DLY:   ans_low_dly  = v & DLY_MASK;
            CSR_RESP_HIGH_DLY:  ans_high_dly = v & DLY_MASK;
            CSR_PRE_DATA_DLY:   pre_dly      = v & DLY_MASK;
            CSR_BIT_SAMPLE_DLY: sample_dly   = v & DLY_MASK;
            CSR_WAIT_TIMEOUT:   edge_timeout = v;
            default: ;
         endcase
      endfunction

      // Saturating count; true once the limit is reached.
      function bit count_hit(int unsigned lim);
         if (tick_cnt < TIMER_MAX) tick_cnt++;
         if (lim > TIMER_MAX) lim = TIMER_MAX;
         return tick_cnt >= lim;
      endfunction

      function void go(wire_phase_type p);
         phase    = p;
         tick_cnt = 0;
      endfunction

      function bit close_byte(logic [7:0] v);
         if (byte_idx == BYTE_HUMIDITY) hum = v;
         else if (byte_idx == BYTE_TEMP) temp = v;
         else if (byte_idx == BYTE_CHECKSUM) csum = v;
         if (byte_idx >= BYTE_CHECKSUM) begin
            // 9-bit sum: an overflowing sum never matches
            stat = ({1'b0, csum} == {1'b0, hum} + {1'b0, temp}) ? STATUS_OK
                                                                : STATUS_BAD_CHECKSUM;
            go(ST_IDLE);
            return 1;
         end
         byte_idx++;
         bit_idx   = 0;
         shift_val = '0;
         go(ST_WAIT_HIGH);
         return 0;
      endfunction

      function bit advance_bit();
         if (bit_idx >= 7) return close_byte(shift_val);
         bit_idx++;
         go(ST_WAIT_HIGH);
         return 0;
      endfunction

      function void note_tick(bit start, bit line);
         tick_result_type r;
         bit              done;
         done = 0;
         case (phase)
            ST_IDLE: begin
               if (start) begin
                  answered = 0;
                  go(ST_START_LOW);
               end
            end
            ST_START_LOW:  if (count_hit(low_ticks)) go(ST_START_HIGH);
            ST_START_HIGH: if (count_hit(high_ticks)) go(ST_RESP_LOW);
            ST_RESP_LOW: begin
               if (count_hit(ans_low_dly)) begin
                  if (!line) begin
                     go(ST_RESP_HIGH);
                  end else begin
                     stat = STATUS_NO_RESPONSE;
                     go(ST_IDLE);
                     done = 1;
                  end
               end
            end
            ST_RESP_HIGH: begin
               if (count_hit(ans_high_dly)) begin
                  answered = line;
                  go(ST_PRE_DATA);
               end
            end
            ST_PRE_DATA: begin
               if (count_hit(pre_dly)) begin
                  if (answered) begin
                     byte_idx  = 0;
                     bit_idx   = 0;
                     shift_val = '0;
                     go(ST_WAIT_HIGH);
                  end else begin
                     stat = STATUS_NO_RESPONSE;
                     go(ST_IDLE);
                     done = 1;
                  end
               end
            end
            ST_WAIT_HIGH: begin
               if (line) go(ST_SAMPLE);
               else if (count_hit(edge_timeout)) done = close_byte(TIMEOUT_BYTE);
            end
            ST_SAMPLE: begin
               if (count_hit(sample_dly)) begin
                  shift_val[7 - bit_idx] = line;
                  if (line) go(ST_WAIT_LOW);
                  else done = advance_bit();
               end
            end
            ST_WAIT_LOW: begin
               if (!line) done = advance_bit();
               else if (count_hit(edge_timeout)) done = close_byte(TIMEOUT_BYTE);
            end
            default: go(ST_IDLE);
         endcase
         r.drv_en  = (phase == ST_START_LOW) || (phase == ST_START_HIGH);
         r.drv_lvl = (phase == ST_START_HIGH);
         r.busy    = (phase != ST_IDLE);
         r.done    = done;
         r.status  = stat;
         r.hum     = hum;
         r.temp_c  = temp;
         r.temp_f  = 9'(int'(temp) * 9 / 5 + 32);
         expected_q.push_back(r);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void cmp_field(string name, logic [8:0] want, logic [8:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_result(logic [RSP_W-1:0] d);
         tick_result_type want, got;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: result word %h with nothing expected", $time, d);
            return;
         end
         want = expected_q.pop_front();
         got  = tick_result_type'(d[30:0]);
         cmp_field("drive_enable", 9'(want.drv_en), 9'(got.drv_en));
         cmp_field("drive_level", 9'(want.drv_lvl), 9'(got.drv_lvl));
         cmp_field("busy", 9'(want.busy), 9'(got.busy));
         cmp_field("done", 9'(want.done), 9'(got.done));
         cmp_field("status", 9'(want.status), 9'(got.status));
         cmp_field("humidity", 9'(want.hum), 9'(got.hum));
         cmp_field("temperature_c", 9'(want.temp_c), 9'(got.temp_c));
         cmp_field("temperature_f", want.temp_f, got.temp_f);
      endfunction
   endclass

   logic                   clock;
   logic                   reset      = 1'b1;
   logic [REQ_W-1:0]       req_tdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_W-1:0]       rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = CSR_START_LOW;
   logic [CFG_W-1:0]       csr_wdata  = '0;

   reading_scoreboard sb;
   int                gap_pct = 34;
   reading_kind_type  rd_mode;
   logic [7:0]        frame [5];
   int unsigned       low_run, high_run, ticks_sent;

   single_wire_sensor_reader u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= gap_pct);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // Hold valid until the word is taken; the caller lowers it when it stops sending.
   task automatic send_word(bit start, bit line);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= {{(REQ_W - 2){1'b0}}, line, start};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_tick(start, line);
      ticks_sent++;
   endtask

   task automatic drain_input();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic put_reg(logic [CSR_INDEX_W-1:0] idx, logic [15:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, v);
   endtask

   task automatic write_config(logic [15:0] v0, logic [15:0] v1, logic [15:0] v2,
                               logic [15:0] v3, logic [15:0] v4, logic [15:0] v5,
                               logic [15:0] v6);
      put_reg(CSR_START_LOW, v0);
      put_reg(CSR_RELEASE, v1);
      put_reg(CSR_RESP_LOW_DLY, v2);
      put_reg(CSR_RESP_HIGH_DLY, v3);
      put_reg(CSR_PRE_DATA_DLY, v4);
      put_reg(CSR_BIT_SAMPLE_DLY, v5);
      put_reg(CSR_WAIT_TIMEOUT, v6);
      // index past the register list must be dropped
      put_reg(CSR_UNUSED, 16'($urandom));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] short_delay();
      // upper bits land above the 10-bit register and are dropped
      return 16'($urandom_range(0, 3) | ($urandom_range(0, 63) << DLY_W));
   endfunction

   task automatic random_config();
      logic [15:0] tmo;
      case ($urandom_range(0, 5))
         0:       tmo = 16'd0;
         1:       tmo = 16'd1;
         5:       tmo = 16'hFFFF;
         default: tmo = 16'($urandom_range(2, 8));
      endcase
      write_config(16'($urandom_range(0, 8)), short_delay(), short_delay(), short_delay(),
                   short_delay(), short_delay(), tmo);
   endtask

   function automatic void plan_frame(reading_kind_type kind);
      rd_mode = kind;
      for (int i = 0; i < 5; i++) frame[i] = 8'($urandom);
      if (kind == RD_SUM_OVERFLOW) begin
         frame[BYTE_HUMIDITY] = 8'($urandom_range(1, 255));
         frame[BYTE_TEMP]     = 8'($urandom_range(256 - frame[BYTE_HUMIDITY], 255));
         frame[BYTE_CHECKSUM] = frame[BYTE_HUMIDITY] + frame[BYTE_TEMP];
      end else begin
         frame[BYTE_HUMIDITY] = 8'($urandom_range(0, 255 - frame[BYTE_TEMP]));
         frame[BYTE_CHECKSUM] = frame[BYTE_HUMIDITY] + frame[BYTE_TEMP];
         if (kind == RD_BAD_SUM) frame[BYTE_CHECKSUM] += 8'($urandom_range(1, 255));
      end
   endfunction

   function automatic reading_kind_type pick_kind();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return RD_OK;
      if (r < 60) return RD_BAD_SUM;
      if (r < 70) return RD_SUM_OVERFLOW;
      if (r < 85) return RD_TIMEOUTS;
      if (r < 93) return RD_NO_LOW;
      return RD_NO_HIGH;
   endfunction

   // Length of the sensor's level before the awaited edge; a stuck line forces a timeout.
   function automatic int unsigned wait_len();
      int unsigned eff;
      eff = (sb.edge_timeout == 0) ? 1 : sb.edge_timeout;
      if (rd_mode == RD_TIMEOUTS && eff <= 64 && $urandom_range(0, 15) == 0) return eff;
      return $urandom_range(0, (eff > 4) ? 3 : eff - 1);
   endfunction

   function automatic bit at_sample(int unsigned d);
      return sb.tick_cnt + 1 >= ((d == 0) ? 1 : d);
   endfunction

   // Sensor side: pick the line level for the next tick from the predicted phase.
   function automatic void next_word(output bit start, output bit line);
      start = 1'($urandom_range(0, 1));
      line  = 1'($urandom_range(0, 1));
      case (sb.phase)
         ST_IDLE:      start = 1'b0;
         ST_RESP_LOW:  if (at_sample(sb.ans_low_dly)) line = (rd_mode == RD_NO_LOW);
         ST_RESP_HIGH: if (at_sample(sb.ans_high_dly)) line = (rd_mode != RD_NO_HIGH);
         ST_WAIT_HIGH: begin
            if (sb.tick_cnt == 0) low_run = wait_len();
            line = (sb.tick_cnt >= low_run);
         end
         ST_SAMPLE: begin
            if (at_sample(sb.sample_dly)) line = frame[sb.byte_idx][7 - sb.bit_idx];
         end
         ST_WAIT_LOW: begin
            if (sb.tick_cnt == 0) high_run = wait_len();
            line = (sb.tick_cnt < high_run);
         end
         default: ;
      endcase
   endfunction

   task automatic run_reading();
      bit s, l;
      repeat ($urandom_range(0, 3)) send_word(1'b0, 1'($urandom_range(0, 1)));
      send_word(1'b1, 1'($urandom_range(0, 1)));
      while (sb.phase != ST_IDLE) begin
         next_word(s, l);
         send_word(s, l);
      end
   endtask

   initial begin
      sb = new();
      ticks_sent = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults: idle ticks, then a short start pulse with the other delays at reset
      send_word(1'b0, 1'b0);
      send_word(1'b0, 1'b1);
      drain_input();
      put_reg(CSR_START_LOW, 16'd3);
      csr_valid <= 1'b0;
      @(posedge clock);
      plan_frame(RD_NO_LOW);
      run_reading();
      drain_input();

      // all-zero registers with no idling, zero timeout acts as one
      gap_pct = 0;
      write_config('0, '0, '0, '0, '0, '0, '0);
      plan_frame(RD_OK);
      frame[BYTE_HUMIDITY] = 8'd0;
      frame[BYTE_TEMP]     = 8'd255;
      frame[BYTE_CHECKSUM] = 8'd255;
      run_reading();
      plan_frame(RD_BAD_SUM);
      run_reading();
      plan_frame(RD_SUM_OVERFLOW);
      frame[BYTE_HUMIDITY] = 8'd255;
      frame[BYTE_TEMP]     = 8'd255;
      frame[BYTE_CHECKSUM] = 8'd254;
      run_reading();
      plan_frame(RD_NO_LOW);
      run_reading();
      plan_frame(RD_NO_HIGH);
      run_reading();
      plan_frame(RD_TIMEOUTS);
      run_reading();
      gap_pct = 34;

      while (ticks_sent < 750) begin
         drain_input();
         random_config();
         plan_frame(pick_kind());
         run_reading();
      end

      req_tvalid <= 1'b0;
      for (int n = 0; n < 2000 && sb.pending() != 0; n++) @(posedge clock);
      repeat (4) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.errors++;
         $display("%0t: %0d expected results never arrived", $time, sb.pending());
      end
      if (sb.errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/swsr_pkg.sv
hw/rtl/single_wire_sensor_reader.sv
tb/tb_single_wire_sensor_reader.sv
